@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

  // Matrix entry and quaternion component widths.
  localparam int unsigned M_W    = 16;
  localparam int unsigned D_W    = M_W + 1;   // sum or difference of two entries
  localparam int unsigned A_W    = M_W + 3;   // square-root argument, signed
  localparam int unsigned ARG_W  = 29;        // argument times 4096, unsigned
  localparam int unsigned ROOT_W = 15;        // rounded root fits in 15 bits
  localparam int unsigned REM_W  = 30;        // dividend and divider remainder
  localparam int unsigned NLANE  = 4;

  localparam logic signed [M_W-1:0] QONE = 16'sd16384;

  // Component lanes, in output order.
  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_Z = 2'd2;
  localparam logic [1:0] LANE_W = 2'd3;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic                        bad;
    logic [1:0]                  idx;   // lane that takes the square root
    logic [ARG_W-1:0]            arg;   // zero when the argument is not positive
    logic [NLANE-1:0][D_W-1:0]   d;     // dividend per lane, signed
  } cls_t;

  typedef struct packed {
    logic                        bad;
    logic [NLANE-1:0][M_W-1:0]   q;     // x, y, z, w
  } res_t;

endpackage

@@ rtl/rmq_fifo.sv @@
module rmq_fifo import rmq_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/rmq_front.sv @@
module rmq_front import rmq_pkg::*; (
  input  logic [M_W-1:0] m00, m01, m02,
  input  logic [M_W-1:0] m10, m11, m12,
  input  logic [M_W-1:0] m20, m21, m22,
  output cls_t           cls
);

  logic signed [A_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [A_W-1:0] trace, arg_s, aii, ajj, akk;
  logic [1:0]            sel;

  always_comb begin
    e00 = A_W'($signed(m00)); e01 = A_W'($signed(m01)); e02 = A_W'($signed(m02));
    e10 = A_W'($signed(m10)); e11 = A_W'($signed(m11)); e12 = A_W'($signed(m12));
    e20 = A_W'($signed(m20)); e21 = A_W'($signed(m21)); e22 = A_W'($signed(m22));
    trace = e00 + e11 + e22;

    // Largest diagonal entry, ties keep the lower index.
    sel = LANE_X;
    if (e11 > e00) sel = LANE_Y;
    if (e22 > ((sel == LANE_Y) ? e11 : e00)) sel = LANE_Z;

    aii = e00; ajj = e11; akk = e22;
    cls.d = '0;
    if (trace > 0) begin
      cls.idx = LANE_W;
      arg_s   = trace + A_W'(QONE);
      cls.d[LANE_X] = D_W'(e21 - e12);
      cls.d[LANE_Y] = D_W'(e02 - e20);
      cls.d[LANE_Z] = D_W'(e10 - e01);
    end else begin
      cls.idx = sel;
      unique case (sel)
        LANE_Y: begin
          aii = e11; ajj = e22; akk = e00;
          cls.d[LANE_W] = D_W'(e02 - e20);
          cls.d[LANE_Z] = D_W'(e21 + e12);
          cls.d[LANE_X] = D_W'(e01 + e10);
        end
        LANE_Z: begin
          aii = e22; ajj = e00; akk = e11;
          cls.d[LANE_W] = D_W'(e10 - e01);
          cls.d[LANE_X] = D_W'(e02 + e20);
          cls.d[LANE_Y] = D_W'(e12 + e21);
        end
        default: begin
          cls.d[LANE_W] = D_W'(e21 - e12);
          cls.d[LANE_Y] = D_W'(e10 + e01);
          cls.d[LANE_Z] = D_W'(e20 + e02);
        end
      endcase
      arg_s = aii - ajj - akk + A_W'(QONE);
    end

    cls.bad = (arg_s <= 0);
    cls.arg = cls.bad ? '0 : {arg_s[16:0], 12'd0};
  end

endmodule

@@ rtl/rmq_back.sv @@
module rmq_back import rmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  cls_t in_cls,
  output logic out_valid,
  output res_t out_res
);

  localparam int unsigned SQ_N = ROOT_W;
  localparam int unsigned DV_N = ROOT_W;

  typedef struct packed {
    logic                      bad;
    logic [1:0]                idx;
    logic [NLANE-1:0][D_W-1:0] d;
  } spl_t;

  typedef struct packed {
    logic                      bad;
    logic [1:0]                idx;
    logic [ROOT_W-1:0]         h;
    logic [NLANE-1:0]          neg;
    logic [NLANE-1:0]          nz;
    logic [NLANE-1:0]          ovf;
  } dpl_t;

  // Square-root stages.
  logic [SQ_N:0]     sv_r;
  spl_t              sp_r    [SQ_N+1];
  logic [ARG_W-1:0]  srem_r  [SQ_N+1];
  logic [ROOT_W-1:0] sroot_r [SQ_N+1];

  // Rounding stage.
  logic              rv_r;
  spl_t              rp_r;
  logic [ROOT_W-1:0] rh_r;

  // Divider stages, one quotient bit per stage on all four lanes.
  logic [DV_N:0]     dv_r;
  dpl_t              dp_r   [DV_N+1];
  logic [REM_W-1:0]  drem_r [DV_N+1][NLANE];
  logic [ROOT_W-1:0] dq_r   [DV_N+1][NLANE];

  logic              fv_r;
  res_t              fres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      rv_r <= 1'b0;
      dv_r <= '0;
      fv_r <= 1'b0;
    end else if (en) begin
      sv_r <= {sv_r[SQ_N-1:0], in_valid};
      rv_r <= sv_r[SQ_N];
      dv_r <= {dv_r[DV_N-1:0], rv_r};
      fv_r <= dv_r[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r[0].bad <= in_cls.bad;
      sp_r[0].idx <= in_cls.idx;
      sp_r[0].d   <= in_cls.d;
      srem_r[0]   <= in_cls.arg;
      sroot_r[0]  <= '0;
    end
  end

  for (genvar s = 0; s < SQ_N; s++) begin : g_sq
    localparam int unsigned B = SQ_N - 1 - s;
    logic [ARG_W:0]    trial, rem_x;
    logic [ARG_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      rem_x    = (ARG_W+1)'(srem_r[s]);
      trial    = ((ARG_W+1)'(sroot_r[s]) << (B + 1)) | ((ARG_W+1)'(1) << (2 * B));
      rem_nxt  = srem_r[s];
      root_nxt = sroot_r[s];
      if (rem_x >= trial) begin
        rem_nxt  = ARG_W'(rem_x - trial);
        root_nxt = sroot_r[s] | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[s+1]    <= sp_r[s];
        srem_r[s+1]  <= rem_nxt;
        sroot_r[s+1] <= root_nxt;
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  always_ff @(posedge clk) begin
    if (en) begin
      rp_r <= sp_r[SQ_N];
      rh_r <= sroot_r[SQ_N] +
              ROOT_W'(srem_r[SQ_N] > ARG_W'(sroot_r[SQ_N]));
    end
  end

  // Dividend set-up: magnitude times 4096 plus half the divisor.
  for (genvar l = 0; l < NLANE; l++) begin : g_prep
    logic signed [D_W-1:0] dl;
    logic [D_W-1:0]        mag;
    logic [REM_W-1:0]      num;

    always_comb begin
      dl  = $signed(rp_r.d[l]);
      mag = dl[D_W-1] ? D_W'(-dl) : D_W'(dl);
      num = REM_W'({mag, 12'd0}) + REM_W'(rh_r >> 1);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[0][l]  <= num;
        dq_r[0][l]    <= '0;
        dp_r[0].neg[l] <= dl[D_W-1];
        dp_r[0].nz[l]  <= (dl != '0);
        dp_r[0].ovf[l] <= (num >= {rh_r, 15'd0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_r[0].bad <= rp_r.bad;
      dp_r[0].idx <= rp_r.idx;
      dp_r[0].h   <= rh_r;
    end
  end

  for (genvar s = 0; s < DV_N; s++) begin : g_dv
    localparam int unsigned B = DV_N - 1 - s;
    logic [REM_W-1:0] dsh;

    assign dsh = REM_W'(dp_r[s].h) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        dp_r[s+1] <= dp_r[s];
      end
    end

    for (genvar l = 0; l < NLANE; l++) begin : g_ln
      always_ff @(posedge clk) begin
        if (en) begin
          if (drem_r[s][l] >= dsh) begin
            drem_r[s+1][l] <= drem_r[s][l] - dsh;
            dq_r[s+1][l]   <= dq_r[s][l] | (ROOT_W'(1) << B);
          end else begin
            drem_r[s+1][l] <= drem_r[s][l];
            dq_r[s+1][l]   <= dq_r[s][l];
          end
        end
      end
    end
  end

  // Final selection and saturation per lane.
  for (genvar l = 0; l < NLANE; l++) begin : g_fin
    logic [M_W-1:0] mag, val;
    dpl_t           p;

    always_comb begin
      p   = dp_r[DV_N];
      mag = (p.ovf[l] || (dq_r[DV_N][l] > ROOT_W'(QONE))) ? QONE : M_W'(dq_r[DV_N][l]);
      if (p.idx == 2'(l)) begin
        val = p.bad ? '0 : ((p.h > ROOT_W'(QONE)) ? QONE : M_W'(p.h));
      end else if (p.h == '0) begin
        val = !p.nz[l] ? '0 : (p.neg[l] ? M_W'(-QONE) : QONE);
      end else begin
        val = p.neg[l] ? M_W'(-mag) : mag;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fres_r.q[l] <= val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fres_r.bad <= dp_r[DV_N].bad;
    end
  end

  assign out_valid = fv_r;
  assign out_res   = fres_r;

endmodule

@@ rtl/rotation_matrix_to_quaternion_unit.sv @@
// Throughput: one matrix per cycle while the result queue has room; 15 square-root
// stages and 15 divider stages, one bit each, are fully pipelined.
// Reset: synchronous, active low; both queues are emptied and all stage valid
// bits cleared. Data and queue storage registers are not reset.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  // Input queue side.
  input  logic           push,
  output logic           full,
  input  logic [M_W-1:0] in_m00, in_m01, in_m02,
  input  logic [M_W-1:0] in_m10, in_m11, in_m12,
  input  logic [M_W-1:0] in_m20, in_m21, in_m22,
  // Result queue side.
  output logic           empty,
  input  logic           pop,
  output logic [M_W-1:0] out_qx,
  output logic [M_W-1:0] out_qy,
  output logic [M_W-1:0] out_qz,
  output logic [M_W-1:0] out_qw,
  output logic           out_bad_input
);

  // The front part classifies each beat as it arrives: it forms the trace,
  // picks the component that comes from the square root, and works out the
  // other three dividends. The record waits in a short queue for the back part.
  cls_t cls_in, cls_q;
  logic mid_empty, mid_pop;

  rmq_front u_front (
    .m00(in_m00), .m01(in_m01), .m02(in_m02),
    .m10(in_m10), .m11(in_m11), .m12(in_m12),
    .m20(in_m20), .m21(in_m21), .m22(in_m22),
    .cls(cls_in)
  );

  rmq_fifo #(.WIDTH($bits(cls_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(cls_in),
    .full   (full),
    .pop    (mid_pop),
    .rd_data(cls_q),
    .empty  (mid_empty)
  );

  // The back part is one pipeline that moves as a whole whenever the result
  // queue has room, so a stalled consumer freezes it without losing a beat.
  logic back_en, back_valid, res_full;
  res_t back_res, res_q;

  assign back_en = ~res_full;
  assign mid_pop = back_en & ~mid_empty;

  rmq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (back_en),
    .in_valid (~mid_empty),
    .in_cls   (cls_q),
    .out_valid(back_valid),
    .out_res  (back_res)
  );

  rmq_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (back_en & back_valid),
    .wr_data(back_res),
    .full   (res_full),
    .pop    (pop),
    .rd_data(res_q),
    .empty  (empty)
  );

  assign out_qx        = res_q.q[LANE_X];
  assign out_qy        = res_q.q[LANE_Y];
  assign out_qz        = res_q.q[LANE_Z];
  assign out_qw        = res_q.q[LANE_W];
  assign out_bad_input = res_q.bad;

endmodule
